>>> rtl/core/gpw_pkg.sv
// Shared types, constants and the microcode table of the graphic LCD
// pixel write engine. No dependencies.
package gpw_pkg;

   // Panel geometry
   localparam int BYTE_COLUMNS = 16;
   localparam int PIXEL_ROWS   = 64;
   localparam int HALF_ROWS    = 32;
   localparam int SHADOW_DEPTH = BYTE_COLUMNS * PIXEL_ROWS;
   localparam int BCOL_W       = $clog2(BYTE_COLUMNS);
   localparam int ROW_W        = $clog2(PIXEL_ROWS);
   localparam int ADDR_W       = $clog2(SHADOW_DEPTH);
   localparam int HALF_W       = $clog2(HALF_ROWS);

   // Panel command bytes
   localparam logic [7:0] SET_ADDR_CMD   = 8'h80;
   localparam logic [7:0] LOWER_HALF_CMD = 8'h88;
   localparam logic [7:0] SYNC_BYTE      = 8'hF8;
   localparam logic [7:0] LEFT_PIXEL     = 8'h80;

   // Item commands
   localparam logic CMD_BYTE  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   // Sequencer steps
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_WAIT   = 3'd0;
   localparam logic [STEP_W-1:0] STEP_ROW    = 3'd1;
   localparam logic [STEP_W-1:0] STEP_WORD   = 3'd2;
   localparam logic [STEP_W-1:0] STEP_NBR    = 3'd3;
   localparam logic [STEP_W-1:0] STEP_LASTB  = 3'd4;

   // Step sequencing conditions
   localparam logic [1:0] COND_WAIT = 2'd0;  // hold until a request is taken
   localparam logic [1:0] COND_NEXT = 2'd1;  // fall through
   localparam logic [1:0] COND_EVEN = 2'd2;  // jump to target on even byte column
   localparam logic [1:0] COND_GOTO = 2'd3;  // jump to target

   // Transfer byte sources
   localparam logic [1:0] SEL_ROW  = 2'd0;
   localparam logic [1:0] SEL_WORD = 2'd1;
   localparam logic [1:0] SEL_NBR  = 2'd2;
   localparam logic [1:0] SEL_NEW  = 2'd3;

   typedef struct packed {
      logic              take;     // step accepts a request
      logic [1:0]        cond;
      logic [STEP_W-1:0] target;
      logic              emit;     // step delivers one transfer
      logic [1:0]        sel;
      logic              is_data;
      logic              last;
      logic              rd_cur;   // read addressed byte
      logic              rd_nbr;   // read even neighbor byte
      logic              wr_cur;   // write updated byte
   } gpw_uword_type;

   // Per-cycle actions handed from sequencer to datapath, already gated
   typedef struct packed {
      logic       req_ready;
      logic       accept;
      logic       emit;
      logic [1:0] sel;
      logic       is_data;
      logic       last;
      logic       rd_cur;
      logic       rd_nbr;
      logic       wr_cur;
   } gpw_act_type;

   // Microcode program
   function automatic gpw_uword_type gpw_ucode(input logic [STEP_W-1:0] step);
      gpw_uword_type uw;
      uw = '0;
      case (step)
         STEP_WAIT: begin
            uw.take = 1'b1;
            uw.cond = COND_WAIT;
         end
         STEP_ROW: begin
            uw.cond   = COND_NEXT;
            uw.emit   = 1'b1;
            uw.sel    = SEL_ROW;
            uw.rd_cur = 1'b1;
         end
         STEP_WORD: begin
            uw.cond   = COND_EVEN;
            uw.target = STEP_LASTB;
            uw.emit   = 1'b1;
            uw.sel    = SEL_WORD;
            uw.wr_cur = 1'b1;
            uw.rd_nbr = 1'b1;
         end
         STEP_NBR: begin
            uw.cond    = COND_NEXT;
            uw.emit    = 1'b1;
            uw.sel     = SEL_NBR;
            uw.is_data = 1'b1;
         end
         STEP_LASTB: begin
            uw.cond    = COND_GOTO;
            uw.target  = STEP_WAIT;
            uw.emit    = 1'b1;
            uw.sel     = SEL_NEW;
            uw.is_data = 1'b1;
            uw.last    = 1'b1;
         end
         default: begin
            uw.cond   = COND_GOTO;
            uw.target = STEP_WAIT;
         end
      endcase
      return uw;
   endfunction

endpackage

>>> rtl/core/gpw_shadow.sv
// Shadow of the panel graphic RAM: one write and one registered read port,
// with a clearing pass after reset. Depends on gpw_pkg.
module gpw_shadow (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [gpw_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                 rd_data,
   input  logic                       wr_en,
   input  logic [gpw_pkg::ADDR_W-1:0] wr_addr,
   input  logic [7:0]                 wr_data,
   output logic                       ready
);
   import gpw_pkg::*;

   logic [7:0]        mem [SHADOW_DEPTH];
   logic [ADDR_W:0]   clr_ff;
   logic [ADDR_W:0]   clr_in;
   logic              clearing;
   logic              we;
   logic [ADDR_W-1:0] wa;
   logic [7:0]        wd;
   logic [7:0]        rd_data_ff;

   // Sweep every entry to zero once after reset
   assign clearing = ~clr_ff[ADDR_W];
   assign clr_in   = clearing ? clr_ff + 1'b1 : clr_ff;
   assign ready    = ~clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // Clearing owns the write port until done
   assign we = clearing | wr_en;
   assign wa = clearing ? clr_ff[ADDR_W-1:0] : wr_addr;
   assign wd = clearing ? 8'h00 : wr_data;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
   end

   // Hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/gpw_sequencer.sv
// Microcode step counter: fetches one control word per step, gates its
// actions on output space and takes conditional jumps. Depends on gpw_pkg.
module gpw_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 shadow_ready,
   input  logic                 out_free,
   input  logic                 bcol_odd,
   output gpw_pkg::gpw_act_type act
);
   import gpw_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic [STEP_W-1:0] nxt;
   gpw_uword_type     uw;
   logic              fire;
   logic              ready;
   logic              accept;

   assign uw     = gpw_ucode(step_ff);
   assign ready  = uw.take & shadow_ready;
   assign accept = ready & req_valid;

   // A step that emits waits for room in the output register
   assign fire = ~uw.emit | out_free;

   // Pick the next step
   always_comb begin
      case (uw.cond)
         COND_WAIT: nxt = accept ? step_ff + 1'b1 : step_ff;
         COND_NEXT: nxt = step_ff + 1'b1;
         COND_EVEN: nxt = bcol_odd ? step_ff + 1'b1 : uw.target;
         COND_GOTO: nxt = uw.target;
         default:   nxt = STEP_WAIT;
      endcase
   end

   assign step_in = fire ? nxt : step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   // Drive gated actions
   always_comb begin
      act           = '0;
      act.req_ready = ready;
      act.accept    = accept;
      act.emit      = uw.emit & fire;
      act.sel       = uw.sel;
      act.is_data   = uw.is_data;
      act.last      = uw.last;
      act.rd_cur    = uw.rd_cur & fire;
      act.rd_nbr    = uw.rd_nbr & fire;
      act.wr_cur    = uw.wr_cur & fire;
   end

endmodule

>>> rtl/core/graphic_lcd_pixel_write_engine_unit.sv
// Top level of the graphic LCD pixel write engine: request registers,
// byte update and transfer output stage. Depends on gpw_pkg, gpw_shadow
// and gpw_sequencer.

// Each request updates a 1024-byte shadow of a 128x64 panel's graphic RAM
// (a whole byte for cmd 0, one pixel for cmd 1) and then delivers the panel
// transfers one per response: row address, word address, the even neighbor
// byte when the byte column is odd, and the addressed byte, flagged last.
// After reset the shadow is cleared by a pass over every entry, during which
// req_stall stays high. The microcode step counter issues one transfer per
// step through a single output register, and takes the next request only
// after the last transfer of the current one; a step that emits waits
// while rsp_stall holds a response in the output register.
module graphic_lcd_pixel_write_engine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [6:0]  req_col,
   input  logic [5:0]  req_row,
   input  logic [7:0]  req_value,
   input  logic        req_color,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_data,
   output logic [7:0]  rsp_xfer_byte,
   output logic [23:0] rsp_serial_frame,
   output logic        rsp_last
);
   import gpw_pkg::*;

   gpw_act_type       act;
   logic              shadow_ready;
   logic              out_free;
   logic [7:0]        rd_data;

   logic              cmd_ff;
   logic [BCOL_W-1:0] bcol_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [7:0]        value_ff;
   logic              color_ff;
   logic [2:0]        pix_ff;
   logic [7:0]        byte_ff;
   logic [7:0]        byte_in;
   logic [BCOL_W-1:0] bcol_in;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              is_data_ff;
   logic [7:0]        xfer_ff;
   logic [23:0]       frame_ff;
   logic              last_ff;

   logic [7:0]        mask;
   logic [7:0]        row_cmd;
   logic [7:0]        word_cmd;
   logic [7:0]        xfer_in;
   logic [ADDR_W-1:0] cur_addr;
   logic [ADDR_W-1:0] nbr_addr;

   gpw_sequencer u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .shadow_ready (shadow_ready),
      .out_free     (out_free),
      .bcol_odd     (bcol_ff[0]),
      .act          (act)
   );

   assign cur_addr = {row_ff, bcol_ff};
   assign nbr_addr = {row_ff, bcol_ff[BCOL_W-1:1], 1'b0};

   gpw_shadow u_shadow (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (act.rd_cur | act.rd_nbr),
      .rd_addr (act.rd_nbr ? nbr_addr : cur_addr),
      .rd_data (rd_data),
      .wr_en   (act.wr_cur),
      .wr_addr (cur_addr),
      .wr_data (byte_in),
      .ready   (shadow_ready)
   );

   assign req_stall = ~act.req_ready;

   // Capture the request; pixel commands address byte col/8
   assign bcol_in = (req_cmd == CMD_PIXEL) ? req_col[6:3] : req_col[BCOL_W-1:0];

   always_ff @(posedge clock) begin
      if (act.accept) begin
         cmd_ff   <= req_cmd;
         bcol_ff  <= bcol_in;
         row_ff   <= req_row;
         value_ff <= req_value;
         color_ff <= req_color;
         pix_ff   <= req_col[2:0];
      end
   end

   // New byte: the request value for byte commands, else the old shadow byte with one pixel set or cleared
   assign mask = LEFT_PIXEL >> pix_ff;

   always_comb begin
      if (cmd_ff == CMD_BYTE) begin
         byte_in = value_ff;
      end else if (color_ff) begin
         byte_in = rd_data | mask;
      end else begin
         byte_in = rd_data & ~mask;
      end
   end

   always_ff @(posedge clock) begin
      if (act.wr_cur) begin
         byte_ff <= byte_in;
      end
   end

   // Address commands; the lower half reuses rows 0-31 at the 0x88 bank
   assign row_cmd  = SET_ADDR_CMD | {3'b000, row_ff[HALF_W-1:0]};
   assign word_cmd = (row_ff[ROW_W-1] ? LOWER_HALF_CMD : SET_ADDR_CMD)
                     | {5'b00000, bcol_ff[BCOL_W-1:1]};

   always_comb begin
      case (act.sel)
         SEL_ROW:  xfer_in = row_cmd;
         SEL_WORD: xfer_in = word_cmd;
         SEL_NBR:  xfer_in = rd_data;
         SEL_NEW:  xfer_in = byte_ff;
         default:  xfer_in = row_cmd;
      endcase
   end

   // Output register: load on emit, drop when taken
   assign out_free     = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid_in = act.emit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (act.emit) begin
         is_data_ff <= act.is_data;
         xfer_ff    <= xfer_in;
         last_ff    <= act.last;
         frame_ff   <= {SYNC_BYTE | {6'b000000, act.is_data, 1'b0},
                        xfer_in[7:4], 4'h0, xfer_in[3:0], 4'h0};
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_data      = is_data_ff;
   assign rsp_xfer_byte    = xfer_ff;
   assign rsp_serial_frame = frame_ff;
   assign rsp_last         = last_ff;

endmodule

>>> tb/graphic_lcd_pixel_write_engine_unit_test.sv
// Testbench for the graphic LCD pixel write engine: drives byte and pixel
// requests, predicts the panel transfer sequence from a shadow copy of the
// graphic RAM and checks every response. Depends on gpw_pkg and the RTL.
`timescale 1ns / 100ps

module graphic_lcd_pixel_write_engine_unit_test;
   import gpw_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_REQS = 300;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN_WAIT  = 20;

   typedef struct packed {
      logic       cmd;
      logic [6:0] col;
      logic [5:0] row;
      logic [7:0] value;
      logic       color;
   } pixel_req_type;

   typedef struct packed {
      logic        is_data;
      logic [7:0]  xfer;
      logic [23:0] frame;
      logic        last;
   } panel_xfer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = 1'b0;
   logic [6:0]  req_col = '0;
   logic [5:0]  req_row = '0;
   logic [7:0]  req_value = '0;
   logic        req_color = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_is_data;
   logic [7:0]  rsp_xfer_byte;
   logic [23:0] rsp_serial_frame;
   logic        rsp_last;

   pixel_req_type  pending_reqs[$];
   panel_xfer_type expected_xfers[$];
   pixel_req_type  driven_req;
   logic [7:0]     shadow_mem [SHADOW_DEPTH];
   logic           quiet = 1'b0;
   int             errors = 0;
   int             cycle_count = 0;
   int             req_gap = 0;
   int             rsp_gap = 0;
   int             hold_count = 0;
   int             transfers_taken = 0;
   logic           long_hold_done = 1'b0;

   graphic_lcd_pixel_write_engine_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_col          (req_col),
      .req_row          (req_row),
      .req_value        (req_value),
      .req_color        (req_color),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_is_data      (rsp_is_data),
      .rsp_xfer_byte    (rsp_xfer_byte),
      .rsp_serial_frame (rsp_serial_frame),
      .rsp_last         (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Pack one transfer with its serial frame and queue it
   function automatic void queue_transfer(input logic is_data, input logic [7:0] b,
                                          input logic last);
      panel_xfer_type t;
      t.is_data = is_data;
      t.xfer    = b;
      t.frame   = {SYNC_BYTE | {6'b0, is_data, 1'b0}, b[7:4], 4'b0, b[3:0], 4'b0};
      t.last    = last;
      expected_xfers.push_back(t);
   endfunction

   // Update the shadow for one request and queue the transfers it causes
   task automatic predict_panel_writes(input pixel_req_type r);
      logic [3:0] bcol;
      logic [9:0] idx;
      logic [7:0] mask;
      logic [7:0] row_cmd;
      logic [7:0] word_cmd;
      if (r.cmd == CMD_BYTE) begin
         bcol = r.col[3:0];
         idx = {r.row, bcol};
         shadow_mem[idx] = r.value;
      end else begin
         bcol = r.col[6:3];
         idx = {r.row, bcol};
         mask = LEFT_PIXEL >> r.col[2:0];
         if (r.color)
            shadow_mem[idx] = shadow_mem[idx] | mask;
         else
            shadow_mem[idx] = shadow_mem[idx] & ~mask;
      end
      if (r.row < HALF_ROWS) begin
         row_cmd  = SET_ADDR_CMD | {3'b0, r.row[4:0]};
         word_cmd = SET_ADDR_CMD | {5'b0, bcol[3:1]};
      end else begin
         row_cmd  = SET_ADDR_CMD | 8'(r.row - HALF_ROWS);
         word_cmd = LOWER_HALF_CMD | {5'b0, bcol[3:1]};
      end
      queue_transfer(1'b0, row_cmd, 1'b0);
      queue_transfer(1'b0, word_cmd, 1'b0);
      // odd byte column: resend the even neighbor first
      if (bcol[0])
         queue_transfer(1'b1, shadow_mem[{r.row, bcol[3:1], 1'b0}], 1'b0);
      queue_transfer(1'b1, shadow_mem[idx], 1'b1);
   endtask

   function automatic pixel_req_type make_req(input logic cmd, input logic [6:0] col,
                                              input logic [5:0] row,
                                              input logic [7:0] value,
                                              input logic color);
      pixel_req_type r;
      r.cmd   = cmd;
      r.col   = col;
      r.row   = row;
      r.value = value;
      r.color = color;
      return r;
   endfunction

   // Request driver: predict on accept, then hold, idle or load the next request
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall)
            predict_panel_writes(driven_req);
         if (!(req_valid && req_stall)) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(0, 13);
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               driven_req = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_cmd   <= driven_req.cmd;
               req_col   <= driven_req.col;
               req_row   <= driven_req.row;
               req_value <= driven_req.value;
               req_color <= driven_req.color;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each transfer, then pick the next stall
   always @(posedge clock) begin
      panel_xfer_type exp_x;
      logic           stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            transfers_taken = transfers_taken + 1;
            if (expected_xfers.size() == 0) begin
               $error("response with no request pending: xfer_byte %h", rsp_xfer_byte);
               errors = errors + 1;
            end else begin
               exp_x = expected_xfers.pop_front();
               if (rsp_is_data !== exp_x.is_data) begin
                  $error("is_data: expected %b, actual %b", exp_x.is_data, rsp_is_data);
                  errors = errors + 1;
               end
               if (rsp_xfer_byte !== exp_x.xfer) begin
                  $error("xfer_byte: expected %h, actual %h", exp_x.xfer, rsp_xfer_byte);
                  errors = errors + 1;
               end
               if (rsp_serial_frame !== exp_x.frame) begin
                  $error("serial_frame: expected %h, actual %h", exp_x.frame,
                         rsp_serial_frame);
                  errors = errors + 1;
               end
               if (rsp_last !== exp_x.last) begin
                  $error("last: expected %b, actual %b", exp_x.last, rsp_last);
                  errors = errors + 1;
               end
            end
         end
         // one long hold-off early on lets the block fill up and stall its input
         if (hold_count > 0) begin
            hold_count = hold_count - 1;
            stall_next = 1'b1;
         end else if (!long_hold_done && transfers_taken >= 80) begin
            long_hold_done = 1'b1;
            hold_count = LONG_HOLD - 1;
            stall_next = 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap = rsp_gap - 1;
            stall_next = 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(0, 13);
            stall_next = 1'b1;
         end else begin
            stall_next = 1'b0;
         end
         rsp_stall <= stall_next;
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("graphic_lcd_pixel_write_engine_unit test failed");
         $finish;
      end
   end

   initial begin
      pixel_req_type r;
      foreach (shadow_mem[i])
         shadow_mem[i] = 8'h00;

      // Directed: field extremes, column wrap, odd columns, both halves
      pending_reqs.push_back(make_req(CMD_BYTE, 7'd0, 6'd0, 8'hFF, 1'b0));
      pending_reqs.push_back(make_req(CMD_BYTE, 7'd1, 6'd0, 8'h5A, 1'b0));
      pending_reqs.push_back(make_req(CMD_BYTE, 7'd15, 6'd63, 8'h00, 1'b1));
      pending_reqs.push_back(make_req(CMD_BYTE, 7'd127, 6'd31, 8'hA5, 1'b0));
      pending_reqs.push_back(make_req(CMD_BYTE, 7'd16, 6'd32, 8'h3C, 1'b1));
      pending_reqs.push_back(make_req(CMD_BYTE, 7'd14, 6'd32, 8'hFF, 1'b0));
      pending_reqs.push_back(make_req(CMD_BYTE, 7'd17, 6'd32, 8'h81, 1'b0));
      pending_reqs.push_back(make_req(CMD_PIXEL, 7'd0, 6'd0, 8'hFF, 1'b0));
      pending_reqs.push_back(make_req(CMD_PIXEL, 7'd7, 6'd0, 8'h00, 1'b1));
      pending_reqs.push_back(make_req(CMD_PIXEL, 7'd8, 6'd0, 8'hFF, 1'b0));
      pending_reqs.push_back(make_req(CMD_PIXEL, 7'd15, 6'd0, 8'h00, 1'b1));
      pending_reqs.push_back(make_req(CMD_PIXEL, 7'd127, 6'd63, 8'h00, 1'b1));
      pending_reqs.push_back(make_req(CMD_PIXEL, 7'd120, 6'd63, 8'hAA, 1'b1));
      pending_reqs.push_back(make_req(CMD_PIXEL, 7'd64, 6'd31, 8'h00, 1'b1));
      pending_reqs.push_back(make_req(CMD_PIXEL, 7'd71, 6'd32, 8'h55, 1'b0));
      pending_reqs.push_back(make_req(CMD_BYTE, 7'd9, 6'd1, 8'h80, 1'b1));
      pending_reqs.push_back(make_req(CMD_PIXEL, 7'd72, 6'd1, 8'h00, 1'b0));
      pending_reqs.push_back(make_req(CMD_PIXEL, 7'd79, 6'd1, 8'h00, 1'b1));

      // Random: half land in a small corner so pixel edits pile up on known bytes
      for (int i = 0; i < RANDOM_REQS; i++) begin
         r.cmd   = 1'($urandom_range(0, 1));
         r.value = 8'($urandom_range(0, 255));
         r.color = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 1) == 0) begin
            r.row = 6'($urandom_range(0, 3) + ($urandom_range(0, 1) ? HALF_ROWS : 0));
            if (r.cmd == CMD_BYTE)
               r.col = 7'($urandom_range(0, 3) + BYTE_COLUMNS * $urandom_range(0, 7));
            else
               r.col = 7'($urandom_range(0, 31));
         end else begin
            r.row = 6'($urandom_range(0, 63));
            r.col = 7'($urandom_range(0, 127));
         end
         pending_reqs.push_back(r);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Drop idling for the tail of the run
      while (pending_reqs.size() > 40)
         @(negedge clock);
      quiet = 1'b1;

      while (pending_reqs.size() > 0 || req_valid)
         @(posedge clock);
      while (expected_xfers.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (errors == 0)
         $display("graphic_lcd_pixel_write_engine_unit test passed");
      else
         $display("graphic_lcd_pixel_write_engine_unit test failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/gpw_pkg.sv
rtl/core/gpw_shadow.sv
rtl/core/gpw_sequencer.sv
rtl/core/graphic_lcd_pixel_write_engine_unit.sv
tb/graphic_lcd_pixel_write_engine_unit_test.sv
